// ----- rtl/lzwd_pkg.sv -----
// Shared types and constants for the variable-width LZW decoder.
`default_nettype none
package lzwd_pkg;
   localparam int TABLE_ENTRIES = 8192;
   localparam int STACK_DEPTH   = 8192;
   localparam int MAX_CODE_BITS = 13;

   localparam int TAB_AW = $clog2(TABLE_ENTRIES);
   localparam int ENT_W  = TAB_AW + 1;
   localparam int STK_AW = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int CODE_W = MAX_CODE_BITS;
   localparam int CW_W   = 4;
   localparam int BUF_W  = 21;
   localparam int BCNT_W = 5;

   localparam logic [CODE_W-1:0] CLEAR_CODE  = CODE_W'(256);
   localparam logic [ENT_W-1:0]  FIRST_FREE  = ENT_W'(257);
   localparam logic [CW_W-1:0]   START_WIDTH = CW_W'(9);

   typedef struct packed {
      logic       operation;
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic [7:0] out_byte;
      logic       out_valid;
      logic       stream_done;
      logic       fault;
   } rsp_type;

   typedef enum logic [2:0] {
      RES_PUSH, RES_POP, RES_LIT, RES_DONE, RES_NONE, RES_FAULT
   } res_kind_type;

   typedef struct packed {
      logic         sweep;
      logic         load_item;
      logic         push;
      logic         pop_rd;
      logic         take_code;
      logic         literal;
      logic         clear_tbl;
      logic         exp_start;
      logic         tbl_rd;
      logic         walk_push;
      logic         finish;
      logic         restart;
      logic         emit;
      res_kind_type res_kind;
   } cmd_type;

   typedef struct packed {
      logic            sweep_last;
      logic            out_free;
      logic            is_pull;
      logic            stack_nonempty;
      logic            stack_full;
      logic            code_ready;
      logic            ended;
      logic            expect_lit;
      logic            code_is_clear;
      logic            code_ge_nfe;
      logic            walk_small;
      logic [CW_W-1:0] code_width;
   } status_type;
endpackage
`default_nettype wire

// ----- rtl/lzwd_ctrl.sv -----
// Sequencer of the LZW decoder: table sweep, push, pop and chain walk.
`default_nettype none
module lzwd_ctrl import lzwd_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type st,
   output cmd_type         cmd
);
   typedef enum logic [2:0] {SWEEP, IDLE, EXEC, POP_OUT, WALK, WALK_RD} state_type;
   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      cmd.res_kind = RES_NONE;
      state_in  = state_ff;
      req_ready = (state_ff == IDLE) && st.out_free;
      unique case (state_ff)
         SWEEP: begin
            cmd.sweep = 1'b1;
            if (st.sweep_last) state_in = IDLE;
         end
         IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load_item = 1'b1;
               state_in = EXEC;
            end
         end
         EXEC: begin
            priority if (!st.is_pull) begin
               cmd.push = 1'b1; cmd.emit = 1'b1; cmd.res_kind = RES_PUSH;
               state_in = IDLE;
            end else if (st.stack_nonempty) begin
               cmd.pop_rd = 1'b1;
               state_in = POP_OUT;
            end else if (!st.code_ready) begin
               cmd.emit = 1'b1;
               if (st.ended) begin
                  cmd.restart = 1'b1; cmd.res_kind = RES_DONE;
               end
               state_in = IDLE;
            end else if (st.expect_lit) begin
               cmd.take_code = 1'b1; cmd.literal = 1'b1;
               cmd.emit = 1'b1; cmd.res_kind = RES_LIT;
               state_in = IDLE;
            end else if (st.code_is_clear) begin
               cmd.take_code = 1'b1; cmd.clear_tbl = 1'b1;
            end else if (st.code_ge_nfe && st.stack_full) begin
               cmd.restart = 1'b1; cmd.emit = 1'b1; cmd.res_kind = RES_FAULT;
               state_in = IDLE;
            end else begin
               cmd.take_code = 1'b1; cmd.exp_start = 1'b1;
               state_in = WALK;
            end
         end
         POP_OUT: begin
            cmd.emit = 1'b1; cmd.res_kind = RES_POP;
            state_in = IDLE;
         end
         WALK: begin
            priority if (st.walk_small && st.stack_full) begin
               cmd.restart = 1'b1; cmd.emit = 1'b1; cmd.res_kind = RES_FAULT;
               state_in = IDLE;
            end else if (st.walk_small) begin
               cmd.finish = 1'b1;
               state_in = EXEC;
            end else begin
               cmd.tbl_rd = 1'b1;
               state_in = WALK_RD;
            end
         end
         WALK_RD: begin
            if (st.stack_full) begin
               cmd.restart = 1'b1; cmd.emit = 1'b1; cmd.res_kind = RES_FAULT;
               state_in = IDLE;
            end else begin
               cmd.walk_push = 1'b1;
               state_in = WALK;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= SWEEP;
      else       state_ff <= state_in;
   end
endmodule
`default_nettype wire

// ----- rtl/lzwd_dp.sv -----
// Datapath of the LZW decoder: bit buffer, tables, reversal stack, result register.
`default_nettype none
module lzwd_dp import lzwd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    csr_we,
   input  wire logic    csr_wdata,
   input  wire req_type req_data,
   input  wire logic    rsp_ready,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   input  wire cmd_type cmd,
   output status_type   st
);
   logic [7:0]        suffix_mem [TABLE_ENTRIES];
   logic [CODE_W-1:0] prefix_mem [TABLE_ENTRIES];
   logic [7:0]        stack_mem  [STACK_DEPTH];

   req_type           item_ff;
   logic              squash_ff;
   logic [TAB_AW-1:0] sweep_ff;
   logic [BUF_W-1:0]  buf_ff;
   logic [BCNT_W-1:0] bcnt_ff;
   logic [CW_W-1:0]   cw_ff;
   logic [ENT_W-1:0]  nfe_ff;
   logic [CODE_W-1:0] prev_ff, incode_ff, walk_ff;
   logic [7:0]        last_ff;
   logic              expect_ff, header_ff, ended_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [7:0]        sfx_rd_ff, stk_rd_ff;
   logic [CODE_W-1:0] pfx_rd_ff;
   logic              rd_in_range_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic [CW_W-1:0]   top_w;
   logic [ENT_W-1:0]  limit;
   logic [CODE_W-1:0] code;
   logic [BUF_W-1:0]  push_buf;
   logic              push_ok;
   logic              stk_we;
   logic [7:0]        stk_wd;
   logic              tbl_we;
   logic [TAB_AW-1:0] tbl_wa;
   logic [CODE_W-1:0] tbl_wp;
   logic [7:0]        tbl_ws;
   logic [ENT_W-1:0]  nfe_inc;
   rsp_type           res;

   always_comb begin
      top_w = squash_ff ? CW_W'(13) : CW_W'(12);
      if (top_w > CW_W'(MAX_CODE_BITS)) top_w = CW_W'(MAX_CODE_BITS);
      limit = ENT_W'(1) << top_w;
      if (limit > ENT_W'(TABLE_ENTRIES)) limit = ENT_W'(TABLE_ENTRIES);
   end

   assign code     = CODE_W'(buf_ff & BUF_W'((BUF_W'(1) << cw_ff) - BUF_W'(1)));
   assign push_buf = buf_ff | (BUF_W'(item_ff.data_byte) << bcnt_ff);
   assign push_ok  = !ended_ff && (bcnt_ff < BCNT_W'(cw_ff));
   assign nfe_inc  = nfe_ff + ENT_W'(1);

   always_comb begin
      st                = '0;
      st.sweep_last     = &sweep_ff;
      st.out_free       = !rsp_valid_ff || rsp_ready;
      st.is_pull        = item_ff.operation;
      st.stack_nonempty = cnt_ff != '0;
      st.stack_full     = cnt_ff >= CNT_W'(STACK_DEPTH);
      st.code_ready     = bcnt_ff >= BCNT_W'(cw_ff);
      st.ended          = ended_ff;
      st.expect_lit     = expect_ff;
      st.code_is_clear  = code == CLEAR_CODE;
      st.code_ge_nfe    = {1'b0, code} >= nfe_ff;
      st.walk_small     = walk_ff < CLEAR_CODE;
      st.code_width     = cw_ff;
   end

   // stack write port: every push lands at the current count
   always_comb begin
      stk_we = 1'b0;
      stk_wd = last_ff;
      if (cmd.exp_start && st.code_ge_nfe) stk_we = 1'b1;
      if (cmd.finish) begin
         stk_we = 1'b1; stk_wd = walk_ff[7:0];
      end
      if (cmd.walk_push) begin
         stk_we = 1'b1; stk_wd = rd_in_range_ff ? sfx_rd_ff : 8'd0;
      end
   end

   always_comb begin
      tbl_we = 1'b0;
      tbl_wa = nfe_ff[TAB_AW-1:0];
      tbl_wp = prev_ff;
      tbl_ws = walk_ff[7:0];
      if (cmd.sweep) begin
         tbl_we = 1'b1;
         tbl_wa = sweep_ff;
         tbl_wp = '0;
         tbl_ws = (sweep_ff < TAB_AW'(256)) ? sweep_ff[7:0] : 8'd0;
      end else if (cmd.finish && nfe_ff < limit) begin
         tbl_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         prefix_mem[tbl_wa] <= tbl_wp;
         suffix_mem[tbl_wa] <= tbl_ws;
      end
      if (cmd.tbl_rd) begin
         pfx_rd_ff      <= prefix_mem[walk_ff[TAB_AW-1:0]];
         sfx_rd_ff      <= suffix_mem[walk_ff[TAB_AW-1:0]];
         rd_in_range_ff <= {1'b0, walk_ff} < (CODE_W + 1)'(TABLE_ENTRIES);
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) stack_mem[cnt_ff[STK_AW-1:0]] <= stk_wd;
      if (cmd.pop_rd) stk_rd_ff <= stack_mem[STK_AW'(cnt_ff - CNT_W'(1))];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) item_ff <= req_data;
      if (cmd.exp_start) incode_ff <= code;
      if (cmd.exp_start) walk_ff <= st.code_ge_nfe ? prev_ff : code;
      if (cmd.walk_push) walk_ff <= rd_in_range_ff ? pfx_rd_ff : '0;
   end

   always_comb begin
      res = '0;
      unique case (cmd.res_kind)
         RES_PUSH:  res.accepted = push_ok;
         RES_POP:   begin res.out_byte = stk_rd_ff; res.out_valid = 1'b1; end
         RES_LIT:   begin res.out_byte = code[7:0]; res.out_valid = 1'b1; end
         RES_DONE:  res.stream_done = 1'b1;
         RES_FAULT: res.fault = 1'b1;
         RES_NONE:  res = '0;
         default:   res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         squash_ff    <= 1'b0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         buf_ff       <= '0;
         bcnt_ff      <= '0;
         cw_ff        <= START_WIDTH;
         nfe_ff       <= FIRST_FREE;
         prev_ff      <= '0;
         last_ff      <= '0;
         expect_ff    <= 1'b1;
         header_ff    <= 1'b1;
         ended_ff     <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (csr_we) squash_ff <= csr_wdata;
         if (cmd.sweep) sweep_ff <= sweep_ff + TAB_AW'(1);
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= res;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.push && push_ok) begin
            if (item_ff.last_byte) ended_ff <= 1'b1;
            header_ff <= 1'b0;
            // outside squash mode a stream opens with a header item that is dropped
            if (!header_ff || squash_ff) begin
               buf_ff  <= push_buf;
               bcnt_ff <= bcnt_ff + BCNT_W'(8);
            end
         end
         if (cmd.take_code) begin
            buf_ff  <= buf_ff >> cw_ff;
            bcnt_ff <= bcnt_ff - BCNT_W'(cw_ff);
         end
         if (cmd.literal) begin
            expect_ff <= 1'b0;
            last_ff   <= code[7:0];
            prev_ff   <= code;
         end
         if (cmd.clear_tbl) begin
            cw_ff     <= START_WIDTH;
            nfe_ff    <= FIRST_FREE;
            expect_ff <= 1'b1;
         end
         if (stk_we) cnt_ff <= cnt_ff + CNT_W'(1);
         if (cmd.pop_rd) cnt_ff <= cnt_ff - CNT_W'(1);
         if (cmd.finish) begin
            last_ff <= walk_ff[7:0];
            prev_ff <= incode_ff;
            if (nfe_ff < limit) begin
               nfe_ff <= nfe_inc;
               if (nfe_inc >= (ENT_W'(1) << cw_ff) && cw_ff < top_w)
                  cw_ff <= cw_ff + CW_W'(1);
            end
         end
         if (cmd.restart) begin
            cw_ff     <= START_WIDTH;
            nfe_ff    <= FIRST_FREE;
            expect_ff <= 1'b1;
            cnt_ff    <= '0;
            buf_ff    <= '0;
            bcnt_ff   <= '0;
            prev_ff   <= '0;
            last_ff   <= '0;
            header_ff <= 1'b1;
            ended_ff  <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

// ----- rtl/variable_width_lzw_decoder_core.sv -----
// Top level of the variable-width LZW decoder: sequencer plus datapath.
//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/ready    | req_type: operation, data_byte, last_byte
//  rsp_    | out       | rsp_valid/ready    | rsp_type: accepted, out_byte, out_valid, ...
//  csr_    | in        | csr_we             | csr_wdata: squash_mode
// One item at a time. A push is answered from EXEC, a pull that pops from POP_OUT; a
// pull that decodes a code walks its chain through WALK and WALK_RD, with a registered
// table read and one stack write per byte of the chain; a clear code adds an EXEC pass.
// After reset the tables are swept with req_ready low. A new item is taken only once
// the previous result has been or is being taken.
`default_nettype none
module variable_width_lzw_decoder_core import lzwd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_we,
   input  wire logic    csr_wdata
);
   cmd_type    cmd;
   status_type st;

   lzwd_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .st(st), .cmd(cmd)
   );

   lzwd_dp u_dp (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_data(req_data), .rsp_ready(rsp_ready), .rsp_valid(rsp_valid),
      .rsp_data(rsp_data), .cmd(cmd), .st(st)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken while busy");

   a_width_range: assert property (@(posedge clock) disable iff (reset)
      st.code_width >= START_WIDTH && st.code_width <= CW_W'(MAX_CODE_BITS))
      else $error("code width out of range");

   a_fault_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fault |-> !rsp_data.out_valid && !rsp_data.stream_done)
      else $error("fault item carries other flags");

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_rd |-> st.stack_nonempty)
      else $error("pop from empty stack");
endmodule
`default_nettype wire
